[rtl/frred_pkg.sv]
// Shared constants and types for the fraction reduction block.
`default_nettype none

package frred_pkg;

   // Width of the signed fields and of the magnitudes taken from them
   localparam int DATA_WIDTH = 32;
   localparam int MAG_W      = DATA_WIDTH - 1;
   localparam int CNT_W      = $clog2(DATA_WIDTH);

   // Result status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_DIV_ZERO = 1'b1;

   // Sequencer states of the reduction core
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SCALE,
      ST_DIV_N,
      ST_DIV_D,
      ST_DONE
   } frred_state_type;

   // Commands from the top level to the core
   typedef struct packed {
      logic start;
      logic ack;
   } frred_ctl_type;

   // Status from the core to the top level
   typedef struct packed {
      logic done;
      logic err;
   } frred_sts_type;

endpackage

`default_nettype wire

[rtl/frred_core.sv]
// Reduction core: binary GCD and two restoring divisions on one shared subtractor.
`default_nettype none

module frred_core
   import frred_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire frred_ctl_type ctl,
   input  wire logic [MAG_W-1:0] n_mag,
   input  wire logic [MAG_W-1:0] d_mag,
   output frred_sts_type      sts,
   output logic [MAG_W-1:0]   quo_n,
   output logic [MAG_W-1:0]   quo_d
);

   frred_state_type state_ff, state_in;

   logic [MAG_W-1:0] a_ff, a_in;
   logic [MAG_W-1:0] b_ff, b_in;
   logic [MAG_W-1:0] g_ff, g_in;
   logic [MAG_W-1:0] nmag_ff, nmag_in;
   logic [MAG_W-1:0] dmag_ff, dmag_in;
   logic [MAG_W-1:0] rn_ff, rn_in;
   logic [MAG_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             err_ff, err_in;

   // Shared subtractor, one bit wider than its operands for the borrow
   logic [DATA_WIDTH-1:0] op_x;
   logic [DATA_WIDTH-1:0] op_y;
   logic [DATA_WIDTH:0]   sub_res;
   logic                  borrow;
   logic                  qbit;
   logic [MAG_W-1:0]      rem_next;
   logic [MAG_W-1:0]      quo_next;
   logic                  last_bit;

   // Pick subtractor operands by phase
   always_comb begin
      if (state_ff == ST_DIV_N || state_ff == ST_DIV_D) begin
         op_x = {b_ff, a_ff[MAG_W-1]};
         op_y = {1'b0, g_ff};
      end else begin
         op_x = {1'b0, a_ff};
         op_y = {1'b0, b_ff};
      end
   end

   assign sub_res  = {1'b0, op_x} - {1'b0, op_y};
   assign borrow   = sub_res[DATA_WIDTH];

   // One restoring division step
   assign qbit     = ~borrow;
   assign rem_next = borrow ? op_x[MAG_W-1:0] : sub_res[MAG_W-1:0];
   assign quo_next = {a_ff[MAG_W-2:0], qbit};
   assign last_bit = (cnt_ff == CNT_W'(MAG_W - 1));

   // Sequence the GCD, the scaling and both divisions
   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      g_in     = g_ff;
      nmag_in  = nmag_ff;
      dmag_in  = dmag_ff;
      rn_in    = rn_ff;
      rd_in    = rd_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               nmag_in = n_mag;
               dmag_in = d_mag;
               a_in    = n_mag;
               b_in    = d_mag;
               k_in    = '0;
               priority if (d_mag == '0) begin
                  // zero denominator: report, zero outputs
                  err_in   = STATUS_DIV_ZERO;
                  rn_in    = '0;
                  rd_in    = '0;
                  state_in = ST_DONE;
               end else if (n_mag == '0) begin
                  // zero numerator: 0/1
                  err_in   = STATUS_OK;
                  rn_in    = '0;
                  rd_in    = MAG_W'(1);
                  state_in = ST_DONE;
               end else begin
                  err_in   = STATUS_OK;
                  state_in = ST_REDUCE;
               end
            end
         end

         ST_REDUCE: begin
            priority if (a_ff == b_ff) begin
               g_in     = a_ff;
               state_in = ST_SCALE;
            end else if (!a_ff[0] && !b_ff[0]) begin
               // strip a common factor of two
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + CNT_W'(1);
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (borrow) begin
               // keep the larger odd value in a
               a_in = b_ff;
               b_in = a_ff;
            end else begin
               a_in = sub_res[MAG_W-1:0];
            end
         end

         ST_SCALE: begin
            if (k_ff == '0) begin
               a_in     = nmag_ff;
               b_in     = '0;
               cnt_in   = '0;
               state_in = ST_DIV_N;
            end else begin
               // restore the stripped factors of two
               g_in = g_ff << 1;
               k_in = k_ff - CNT_W'(1);
            end
         end

         ST_DIV_N: begin
            a_in   = quo_next;
            b_in   = rem_next;
            cnt_in = cnt_ff + CNT_W'(1);
            if (last_bit) begin
               rn_in    = quo_next;
               a_in     = dmag_ff;
               b_in     = '0;
               cnt_in   = '0;
               state_in = ST_DIV_D;
            end
         end

         ST_DIV_D: begin
            a_in   = quo_next;
            b_in   = rem_next;
            cnt_in = cnt_ff + CNT_W'(1);
            if (last_bit) begin
               rd_in    = quo_next;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (ctl.ack) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance the datapath registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      g_ff    <= g_in;
      nmag_ff <= nmag_in;
      dmag_ff <= dmag_in;
      rn_ff   <= rn_in;
      rd_ff   <= rd_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      err_ff  <= err_in;
   end

   assign sts.done = (state_ff == ST_DONE);
   assign sts.err  = err_ff;
   assign quo_n    = rn_ff;
   assign quo_d    = rd_ff;

endmodule

`default_nettype wire

[rtl/fraction_reduce.sv]
// Top level of the fraction reduction block: handshakes, sign handling, result register.
//
//   channel   direction  handshake          word
//   req_      in         req_valid/stall    numerator_in, denominator_in
//   rsp_      out        rsp_valid/stall    numerator_out, denominator_out, status
//
// One word at a time. A zero numerator or denominator sends the core straight to its
// done state; otherwise the binary GCD steps, the scaling and two restoring divisions
// run first. Reset is synchronous, active high, and clears the sequencer and valid flags.
// A held result under rsp_stall does not block the next request; the core
// waits in its done state until the result register is free.
`default_nettype none

module fraction_reduce
   import frred_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [DATA_WIDTH-1:0] req_numerator_in,
   input  wire logic [DATA_WIDTH-1:0] req_denominator_in,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0]      rsp_numerator_out,
   output logic [MAG_W-1:0]           rsp_denominator_out,
   output logic                       rsp_status
);

   logic busy_ff, busy_in;
   logic neg_ff, neg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [MAG_W-1:0]      den_ff, den_in;
   logic                  status_ff, status_in;

   logic                  accept;
   logic                  load;
   logic [DATA_WIDTH-1:0] n_abs;
   logic [DATA_WIDTH-1:0] d_abs;
   logic [MAG_W-1:0]      n_mag;
   logic [MAG_W-1:0]      d_mag;
   logic [MAG_W-1:0]      quo_n;
   logic [MAG_W-1:0]      quo_d;
   logic [DATA_WIDTH-1:0] num_pos;

   frred_ctl_type ctl;
   frred_sts_type sts;

   assign accept = req_valid && !req_stall;

   // Split into magnitudes, saturating the most negative code
   assign n_abs = req_numerator_in[DATA_WIDTH-1]   ? (~req_numerator_in + DATA_WIDTH'(1))
                                                   : req_numerator_in;
   assign d_abs = req_denominator_in[DATA_WIDTH-1] ? (~req_denominator_in + DATA_WIDTH'(1))
                                                   : req_denominator_in;
   assign n_mag = n_abs[DATA_WIDTH-1] ? {MAG_W{1'b1}} : n_abs[MAG_W-1:0];
   assign d_mag = d_abs[DATA_WIDTH-1] ? {MAG_W{1'b1}} : d_abs[MAG_W-1:0];

   // Take the result when the output register is free
   assign load    = sts.done && (!rsp_valid_ff || !rsp_stall);
   assign ctl.start = accept;
   assign ctl.ack   = load;

   frred_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .n_mag (n_mag),
      .d_mag (d_mag),
      .sts   (sts),
      .quo_n (quo_n),
      .quo_d (quo_d)
   );

   assign num_pos = {1'b0, quo_n};

   // Next values for control and the result register
   always_comb begin
      busy_in      = busy_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      status_in    = status_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         neg_in  = req_numerator_in[DATA_WIDTH-1] ^ req_denominator_in[DATA_WIDTH-1];
      end
      if (load) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         status_in    = sts.err;
         den_in       = quo_d;
         // put the sign of the fraction on the numerator
         if (neg_ff && quo_n != '0) begin
            num_in = ~num_pos + DATA_WIDTH'(1);
         end else begin
            num_in = num_pos;
         end
      end
   end

   // Hold control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      status_ff <= status_in;
   end

   assign req_stall           = busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_numerator_out   = num_ff;
   assign rsp_denominator_out = den_ff;
   assign rsp_status          = status_ff;

endmodule

`default_nettype wire

[bench/fraction_reduce_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for fraction_reduce: predicts each reduced word and checks every result word.
module fraction_reduce_checker
   import frred_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [DATA_WIDTH-1:0] req_numerator_in,
   input  logic [DATA_WIDTH-1:0] req_denominator_in,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [DATA_WIDTH-1:0] rsp_numerator_out,
   input  logic [MAG_W-1:0]      rsp_denominator_out,
   input  logic                  rsp_status,
   output int                    mismatch_count,
   output int                    pending_words
);

   typedef struct packed {
      logic [DATA_WIDTH-1:0] numerator;
      logic [MAG_W-1:0]      denominator;
      logic                  status;
   } fraction_word_type;

   fraction_word_type expected_words[$];
   int                mismatches;

   initial begin
      mismatches     = 0;
      mismatch_count = 0;
      pending_words  = 0;
   end

   // Magnitude of a signed field; the most negative value saturates to the largest magnitude
   function automatic logic [MAG_W-1:0] abs_saturated(input logic [DATA_WIDTH-1:0] value);
      logic [DATA_WIDTH-1:0] negated;
      negated = -value;
      if (!value[DATA_WIDTH-1])
         return value[MAG_W-1:0];
      if (negated[DATA_WIDTH-1])
         return {MAG_W{1'b1}};
      return negated[MAG_W-1:0];
   endfunction

   // Reduce one fraction to lowest terms with the sign on the numerator
   function automatic fraction_word_type reduce_fraction(input logic [DATA_WIDTH-1:0] num_in,
                                                         input logic [DATA_WIDTH-1:0] den_in);
      fraction_word_type word;
      logic [MAG_W-1:0]  num_mag;
      logic [MAG_W-1:0]  den_mag;
      logic [MAG_W-1:0]  a;
      logic [MAG_W-1:0]  b;
      logic [MAG_W-1:0]  rem;
      num_mag = abs_saturated(num_in);
      den_mag = abs_saturated(den_in);
      // zero denominator: zero outputs with error status
      if (den_mag == '0) begin
         word.numerator   = '0;
         word.denominator = '0;
         word.status      = STATUS_DIV_ZERO;
         return word;
      end
      // Euclid; a ends as the gcd, never zero here
      a = num_mag;
      b = den_mag;
      while (b != '0) begin
         rem = a % b;
         a   = b;
         b   = rem;
      end
      word.status      = STATUS_OK;
      word.denominator = den_mag / a;
      word.numerator   = {1'b0, num_mag / a};
      // a zero numerator stays zero under negation, so 0/1 falls out
      if (num_in[DATA_WIDTH-1] != den_in[DATA_WIDTH-1])
         word.numerator = -word.numerator;
      return word;
   endfunction

   always @(posedge clock) begin
      fraction_word_type predicted;
      if (!reset) begin
         // check a result word against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: result word with nothing expected: %0d/%0d status %0b",
                        $time, $signed(rsp_numerator_out), rsp_denominator_out, rsp_status);
               mismatches++;
            end else begin
               predicted = expected_words.pop_front();
               if (rsp_numerator_out !== predicted.numerator) begin
                  $display("%0t: numerator expected %0d, actual %0d", $time,
                           $signed(predicted.numerator), $signed(rsp_numerator_out));
                  mismatches++;
               end
               if (rsp_denominator_out !== predicted.denominator) begin
                  $display("%0t: denominator expected %0d, actual %0d", $time,
                           predicted.denominator, rsp_denominator_out);
                  mismatches++;
               end
               if (rsp_status !== predicted.status) begin
                  $display("%0t: status expected %0b, actual %0b", $time,
                           predicted.status, rsp_status);
                  mismatches++;
               end
            end
         end
         // predict the word just taken in
         if (req_valid && !req_stall)
            expected_words.push_back(reduce_fraction(req_numerator_in, req_denominator_in));
      end
      mismatch_count <= mismatches;
      pending_words  <= expected_words.size();
   end

endmodule

[bench/fraction_reduce_tb.sv]
`timescale 1ns / 1ps
// Testbench top for fraction_reduce: clock, reset, stimulus, receiver idling and the verdict.
module fraction_reduce_tb;
   import frred_pkg::*;

   localparam int HOLD_CYCLES  = 1500;
   localparam int TAIL_CYCLES  = 300;
   localparam int RANDOM_WORDS = 400;
   localparam int QUIET_WORDS  = 30;

   localparam logic [DATA_WIDTH-1:0] MAX_POS  = 32'h7FFF_FFFF;
   localparam logic [DATA_WIDTH-1:0] MOST_NEG = 32'h8000_0000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [DATA_WIDTH-1:0] req_numerator_in;
   logic [DATA_WIDTH-1:0] req_denominator_in;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [DATA_WIDTH-1:0] rsp_numerator_out;
   logic [MAG_W-1:0]      rsp_denominator_out;
   logic                  rsp_status;

   int mismatch_count;
   int pending_words;
   bit idle_enable;
   bit hold_request;

   fraction_reduce dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_numerator_in   (req_numerator_in),
      .req_denominator_in (req_denominator_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_numerator_out  (rsp_numerator_out),
      .rsp_denominator_out(rsp_denominator_out),
      .rsp_status         (rsp_status)
   );

   fraction_reduce_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_numerator_in   (req_numerator_in),
      .req_denominator_in (req_denominator_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_numerator_out  (rsp_numerator_out),
      .rsp_denominator_out(rsp_denominator_out),
      .rsp_status         (rsp_status),
      .mismatch_count     (mismatch_count),
      .pending_words      (pending_words)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Give up if the run hangs
   initial begin
      #20_000_000;
      $display("fraction_reduce_tb: done, errors");
      $finish;
   end

   // Offer one word, at times with a random gap first when idling is on, and hold it until taken
   task automatic offer_word(input logic [DATA_WIDTH-1:0] num, input logic [DATA_WIDTH-1:0] den);
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_numerator_in   <= num;
      req_denominator_in <= den;
      do @(posedge clock); while (req_stall);
   endtask

   // Build a random fraction: raw bits, shared factors, zeros or small values
   task automatic offer_random_word();
      logic [DATA_WIDTH-1:0] num;
      logic [DATA_WIDTH-1:0] den;
      int unsigned           common;
      int unsigned           kind;
      kind   = $urandom_range(0, 9);
      common = $urandom_range(1, 65535);
      num    = $urandom;
      den    = $urandom;
      if (kind >= 4 && kind < 8) begin
         // shared factor so the reduction does real work
         num = common * $urandom_range(0, 32767);
         den = common * $urandom_range(1, 32767);
         if ($urandom_range(0, 1))
            num = -num;
         if ($urandom_range(0, 1))
            den = -den;
      end else if (kind == 8) begin
         if ($urandom_range(0, 1))
            num = '0;
         else
            den = '0;
      end else if (kind == 9) begin
         num = $urandom_range(0, 40) - 20;
         den = $urandom_range(0, 40) - 20;
         if ($urandom_range(0, 7) == 0)
            num = MOST_NEG;
         if ($urandom_range(0, 7) == 0)
            den = MOST_NEG;
      end
      offer_word(num, den);
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
   endtask

   // Receiver: random stall bursts, one long hold-off on request, none when idling is off
   initial begin
      int len;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!idle_enable) begin
            rsp_stall <= 1'b0;
         end else begin
            len = $urandom_range(1, 18);
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat (len - 1) @(negedge clock);
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_numerator_in   = '0;
      req_denominator_in = '0;
      idle_enable        = 1'b1;
      hold_request       = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes of both fields and every sign combination
      offer_word(MAX_POS, 32'd1);
      offer_word(-MAX_POS, 32'd1);
      offer_word(32'd1, MAX_POS);
      offer_word(32'd1, -MAX_POS);
      offer_word(MAX_POS, MAX_POS);
      offer_word(MAX_POS, -MAX_POS);
      offer_word(-MAX_POS, -MAX_POS);
      offer_word(32'd12, 32'd18);
      offer_word(-32'd12, 32'd18);
      offer_word(32'd12, -32'd18);
      offer_word(-32'd12, -32'd18);
      // zero numerator gives 0/1 whatever the denominator's sign
      offer_word(32'd0, 32'd5);
      offer_word(32'd0, -32'd7);
      offer_word(32'd0, MOST_NEG);
      // zero denominator reports the error
      offer_word(32'd5, 32'd0);
      offer_word(-32'd5, 32'd0);
      offer_word(32'd0, 32'd0);
      offer_word(MOST_NEG, 32'd0);
      // most negative value saturates before reduction
      offer_word(MOST_NEG, 32'd2);
      offer_word(32'd6, MOST_NEG);
      offer_word(MOST_NEG, MOST_NEG);
      // long Euclid chain, powers of two, large common factor
      offer_word(32'd1836311903, 32'd1134903170);
      offer_word(32'h4000_0000, 32'h1000_0000);
      offer_word(32'd2147483646, -32'd1073741823);
      wait_drained();

      // hold off the receiver while words keep coming, so the input backs up
      idle_enable  = 1'b0;
      hold_request = 1'b1;
      repeat (6) offer_random_word();
      idle_enable = 1'b1;
      wait_drained();

      repeat (RANDOM_WORDS) offer_random_word();

      // no idling on either side for the last stretch
      idle_enable = 1'b0;
      repeat (QUIET_WORDS) offer_random_word();
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && pending_words == 0)
         $display("fraction_reduce_tb: done, clean");
      else
         $display("fraction_reduce_tb: done, errors");
      $finish;
   end

endmodule
